### hdl/rigw_pkg.sv
// rigw_pkg: shared types and constants for the request id gap window tracker.
// No dependencies.
`timescale 1ns / 1ps
package rigw_pkg;
	localparam int DEF_CLIENT_COUNT = 64;
	// slot = id mod window, taken from the low id bits: must stay a power of two
	localparam int WINDOW_SIZE = 64;

	typedef enum logic [2:0] {
		ACT_FORWARD     = 3'd0,
		ACT_RETRANSMIT  = 3'd1,
		ACT_DROP_AUTH   = 3'd2,
		ACT_DROP_WINDOW = 3'd3,
		ACT_DROP_FULL   = 3'd4
	} action_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_EVAL
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic clr_wr;   // write zero entry at clear address
		logic rd;       // capture request, issue memory read
		logic eval;     // decide and write back
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic clr_last;
	} sts_t;
endpackage

### hdl/rigw_ctrl.sv
// rigw_ctrl: sequencer for clearing pass and per-request read-modify-write.
// Depends on rigw_pkg.
`timescale 1ns / 1ps
module rigw_ctrl import rigw_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	output logic   in_stall,
	input  logic   out_busy,
	input  sts_t   sts,
	output cmd_t   cmd
);
	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_CLEAR;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_stall = 1'b1;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (sts.clr_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.rd = 1'b1;
					state_d = ST_READ;
				end
			end
			ST_READ: state_d = ST_EVAL;
			ST_EVAL: begin
				if (!out_busy) begin
					cmd.eval = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end
endmodule

### hdl/rigw_dpath.sv
// rigw_dpath: client state memory, window decision and bitmap update.
// Depends on rigw_pkg.
`timescale 1ns / 1ps
module rigw_dpath import rigw_pkg::*; #(
	parameter int CLIENT_COUNT = DEF_CLIENT_COUNT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	output sts_t        sts,
	input  logic [5:0]  client_index,
	input  logic [31:0] req_seq,
	input  logic        authentic,
	input  logic        forward_ready,
	input  logic        out_stall,
	output logic        out_busy,
	output logic        out_valid,
	output logic [2:0]  action,
	output logic [31:0] low_mark_after,
	output logic [31:0] high_mark_after
);
	localparam int CW = (CLIENT_COUNT > 1) ? $clog2(CLIENT_COUNT) : 1;
	localparam int SW = $clog2(WINDOW_SIZE);
	localparam int EW = 64 + WINDOW_SIZE;

	// entry: {bitmap, low, high}
	logic [EW-1:0] mem [CLIENT_COUNT];
	logic [EW-1:0] rdata_q;
	logic [CW-1:0] clr_q, cl_q;
	logic [31:0]   rid_q;
	logic          auth_q, rdy_q;
	logic          we;
	logic [CW-1:0] waddr;
	logic [EW-1:0] wdata;

	// client index mod count: conditional subtract of count * 2^k, k = 5..0
	logic [CW-1:0] cl_in;
	logic [15:0]   cl_rem;
	always_comb begin
		cl_rem = 16'(client_index);
		for (int k = 5; k >= 0; k--)
			if (cl_rem >= (16'(CLIENT_COUNT) << k))
				cl_rem = cl_rem - (16'(CLIENT_COUNT) << k);
		cl_in = CW'(cl_rem);
	end

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata_q <= mem[cl_q];
		if (cmd.rd) begin
			cl_q   <= cl_in;
			rid_q  <= req_seq;
			auth_q <= authentic;
			rdy_q  <= forward_ready;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) clr_q <= '0;
		else if (cmd.clr_wr) clr_q <= clr_q + 1'b1;
	end
	assign sts.clr_last = (32'(clr_q) == CLIENT_COUNT - 1);

	// evaluate
	logic [31:0] hi, lo, rid_m_lo, span, lo_n, hi_n;
	logic [WINDOW_SIZE-1:0] bm, bm_n, gap, rot;
	logic [SW-1:0] rslot, hslot;
	logic in_win, miss, upd;
	action_t act;

	always_comb begin
		hi = rdata_q[31:0];
		lo = rdata_q[63:32];
		bm = rdata_q[EW-1:64];
		rid_m_lo = rid_q - lo;
		span = hi - lo;
		rslot = rid_q[SW-1:0];
		hslot = hi[SW-1:0];
		in_win = (rid_q > hi) && (rid_m_lo < 32'(WINDOW_SIZE));
		miss = (rid_q > lo) && (rid_q < hi) && bm[rslot];
		lo_n = lo; hi_n = hi; bm_n = bm; upd = 1'b0;
		gap = '0; rot = '0;
		if (!auth_q) act = ACT_DROP_AUTH;
		else if (in_win) begin
			if (rdy_q) begin
				act = ACT_FORWARD; upd = 1'b1;
				// mark slots hi+1 .. rid-1 (fewer than window size)
				for (int i = 0; i < WINDOW_SIZE; i++)
					gap[i] = (SW'(SW'(i) - hslot - 1'b1) < SW'(rid_q - hi - 1)) &&
					         (rid_q - hi - 1 < 32'(WINDOW_SIZE));
				bm_n = bm | gap;
				hi_n = rid_q;
				if (lo + 1 == rid_q) lo_n = rid_q;
			end else act = ACT_DROP_FULL;
		end else if (miss) begin
			if (rdy_q) begin
				act = ACT_FORWARD; upd = 1'b1;
				bm_n = bm;
				bm_n[rslot] = 1'b0;
				lo_n = hi;
				// rotate so bit d is slot of lo+d; the smallest set d >= 1 below span wins
				rot = (bm_n >> lo[SW-1:0]) | (bm_n << (SW'(WINDOW_SIZE) - lo[SW-1:0]));
				if (lo[SW-1:0] == '0) rot = bm_n;
				for (int d = WINDOW_SIZE - 1; d >= 1; d--)
					if (rot[d] && 32'(d) < span)
						lo_n = lo + 32'(d) - 1;
			end else act = ACT_DROP_FULL;
		end else if (rid_q <= hi) act = ACT_RETRANSMIT;
		else act = ACT_DROP_WINDOW;

		we = cmd.clr_wr || (cmd.eval && upd);
		waddr = cmd.clr_wr ? clr_q : cl_q;
		wdata = cmd.clr_wr ? '0 : {bm_n, lo_n, hi_n};
	end

	logic vq;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vq <= 1'b0;
		else if (cmd.eval) vq <= 1'b1;
		else if (!out_stall) vq <= 1'b0;
	end
	always_ff @(posedge clk) begin
		if (cmd.eval) begin
			action <= act;
			low_mark_after <= lo_n;
			high_mark_after <= hi_n;
		end
	end
	assign out_valid = vq;
	assign out_busy = vq && out_stall;
endmodule

### hdl/request_id_gap_window_tracker_core.sv
// Request id gap window tracker: per-client anti-replay window with gap bitmap.
// Each accepted beat passes the read and evaluate states before its result beat;
// no new request is taken until then, set by the read-modify-write of the client's
// entry in the state memory. After reset a clearing pass zeroes every entry; input
// is stalled during it. Result register lets the next beat in while one waits.
`timescale 1ns / 1ps
module request_id_gap_window_tracker_core import rigw_pkg::*; #(
	parameter int CLIENT_COUNT = DEF_CLIENT_COUNT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [5:0]  client_index,
	input  logic [31:0] req_seq,
	input  logic        authentic,
	input  logic        forward_ready,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  action,
	output logic [31:0] low_mark_after,
	output logic [31:0] high_mark_after
);
	cmd_t cmd;
	sts_t sts;
	logic out_busy;

	// sequencer: clearing pass, then accept / read / evaluate per beat
	rigw_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.out_busy(out_busy), .sts(sts), .cmd(cmd)
	);

	// state memory, decision logic and result register
	rigw_dpath #(.CLIENT_COUNT(CLIENT_COUNT)) u_dpath (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.client_index(client_index), .req_seq(req_seq),
		.authentic(authentic), .forward_ready(forward_ready),
		.out_stall(out_stall), .out_busy(out_busy), .out_valid(out_valid),
		.action(action), .low_mark_after(low_mark_after),
		.high_mark_after(high_mark_after)
	);

`ifndef NO_ASSERTIONS
	// a result beat always carries a defined action code
	a_act: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (action <= ACT_DROP_FULL)) else $error("bad action");
	// evaluate never happens while a result is still held
	a_noovr: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.eval |-> !out_busy) else $error("result overwritten");
	// cycle after an accepted beat the input is stalled
	a_seq: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall) else $error("double accept");
`endif
endmodule

### dv/request_id_gap_window_tracker_core_test.sv
// Self-checking bench for request_id_gap_window_tracker_core: a queue-fed driver,
// a monitor and a behavioral predictor of the per-client windows. Needs rigw_pkg.
`timescale 1ns / 1ps
module request_id_gap_window_tracker_core_test;
	import rigw_pkg::*;

	localparam int NCLI = DEF_CLIENT_COUNT;
	localparam int WIN = WINDOW_SIZE;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic [5:0]  cli;
		logic [31:0] rid;
		logic        auth;
		logic        rdy;
	} req_t;

	typedef struct packed {
		action_t     act;
		logic [31:0] lo;
		logic [31:0] hi;
	} verdict_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [5:0]  client_index;
	logic [31:0] req_seq;
	logic        authentic;
	logic        forward_ready;
	logic        out_valid;
	logic        out_stall;
	logic [2:0]  action;
	logic [31:0] low_mark_after;
	logic [31:0] high_mark_after;

	request_id_gap_window_tracker_core uut (.*);

	// predictor copy of the per-client state
	logic [31:0]    hi_mark [NCLI];
	logic [31:0]    lo_mark [NCLI];
	logic [WIN-1:0] gap_map [NCLI];

	// Rough tracker of the highest id queued per client, to aim ids at the window.
	logic [31:0] aim [NCLI];

	req_t     pending_reqs[$];
	verdict_t expected_verdicts[$];
	int       mismatches;
	int       cycles;
	bit       stim_done;
	bit       in_acc;

	always begin
		clk = 1'b1; #10;
		clk = 1'b0; #10;
	end

	// Window check, gap fill and replay decision for one accepted beat.
	function automatic verdict_t track_request(req_t r);
		int unsigned c;
		logic [31:0] id, lo, span;
		bit found;
		verdict_t v;
		c = r.cli % NCLI;
		lo = lo_mark[c];
		if (!r.auth)
			v.act = ACT_DROP_AUTH;
		else if (r.rid > hi_mark[c] && (r.rid - lo) < WIN) begin
			if (r.rdy) begin
				// mark every skipped id as a gap
				id = hi_mark[c] + 1;
				for (int n = 0; n < WIN && id != r.rid; n++) begin
					gap_map[c][id % WIN] = 1'b1;
					id = id + 1;
				end
				hi_mark[c] = r.rid;
				if (lo + 1 == r.rid)
					lo_mark[c] = r.rid;
				v.act = ACT_FORWARD;
			end else
				v.act = ACT_DROP_FULL;
		end else if (r.rid > lo && r.rid < hi_mark[c] && gap_map[c][r.rid % WIN]) begin
			if (r.rdy) begin
				gap_map[c][r.rid % WIN] = 1'b0;
				span = hi_mark[c] - lo;
				found = 0;
				// low mark lands just below the oldest remaining gap
				for (int unsigned d = 1; d < span && d < WIN; d++) begin
					id = lo + d;
					if (!found && gap_map[c][id % WIN]) begin
						lo_mark[c] = id - 1;
						found = 1;
					end
				end
				if (!found)
					lo_mark[c] = hi_mark[c];
				v.act = ACT_FORWARD;
			end else
				v.act = ACT_DROP_FULL;
		end else if (r.rid <= hi_mark[c])
			v.act = ACT_RETRANSMIT;
		else
			v.act = ACT_DROP_WINDOW;
		v.lo = lo_mark[c];
		v.hi = hi_mark[c];
		return v;
	endfunction

	function automatic req_t mk(int cli, logic [31:0] rid, bit auth, bit rdy);
		req_t r;
		r.cli = cli[5:0];
		r.rid = rid;
		r.auth = auth;
		r.rdy = rdy;
		return r;
	endfunction

	function automatic logic [31:0] hi_mark_guess(int c);
		logic [31:0] g;
		g = aim[c];
		aim[c] = aim[c] + $urandom_range(0, 5);
		return g;
	endfunction

	// input beat taken at the last rising edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			in_acc <= 1'b0;
		else
			in_acc <= in_valid && !in_stall;
	end

	// Driver: bursts of beats separated by random gaps; payload held while stalled.
	int burst_left, gap_left;
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			burst_left <= 0;
			gap_left <= 0;
		end else if (!in_valid || in_acc) begin
			if (gap_left > 0 || pending_reqs.size() == 0) begin
				in_valid <= 1'b0;
				if (gap_left > 0)
					gap_left <= gap_left - 1;
			end else begin
				in_valid <= 1'b1;
				{client_index, req_seq, authentic, forward_ready} <= pending_reqs.pop_front();
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 20);
					gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end else
					burst_left <= burst_left - 1;
			end
		end
	end

	// Receiver stall: runs of free cycles and runs of stall, each of random length.
	int stall_run;
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_run <= 0;
		end else if (stall_run > 0)
			stall_run <= stall_run - 1;
		else begin
			out_stall <= ($urandom_range(0, 2) == 0);
			stall_run <= $urandom_range(0, 12);
		end
	end

	// Monitor: predict on input beats, compare on output beats.
	always @(posedge clk) begin
		verdict_t exp_v;
		if (arst_n) begin
			cycles <= cycles + 1;
			if (in_valid && !in_stall)
				expected_verdicts.push_back(track_request(
					mk(client_index, req_seq, authentic, forward_ready)));
			if (out_valid && !out_stall) begin
				if (expected_verdicts.size() == 0) begin
					mismatches = mismatches + 1;
					if (mismatches <= 10)
						$display("unexpected result beat: action %0d", action);
				end else begin
					exp_v = expected_verdicts.pop_front();
					if (action !== exp_v.act || low_mark_after !== exp_v.lo
							|| high_mark_after !== exp_v.hi) begin
						mismatches = mismatches + 1;
						if (mismatches <= 10)
							$display("mismatch: exp act %0d lo %h hi %h, got act %0d lo %h hi %h",
								exp_v.act, exp_v.lo, exp_v.hi,
								action, low_mark_after, high_mark_after);
					end
				end
			end
		end
	end

	initial begin
		logic [31:0] base;
		int c, k;
		mismatches = 0;
		cycles = 0;
		stim_done = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		out_stall = 1'b0;
		client_index = '0;
		req_seq = '0;
		authentic = 1'b0;
		forward_ready = 1'b0;
		for (int i = 0; i < NCLI; i++) begin
			hi_mark[i] = '0;
			lo_mark[i] = '0;
			gap_map[i] = '0;
			aim[i] = '0;
		end

		// directed: every action, window edges, gap fill, queue-full cases
		pending_reqs.push_back(mk(0, 32'd5, 0, 1));            // unauthentic
		pending_reqs.push_back(mk(0, 32'd1, 1, 1));            // contiguous forward
		pending_reqs.push_back(mk(0, 32'd4, 1, 0));            // queue full on new id
		pending_reqs.push_back(mk(0, 32'd4, 1, 1));            // opens gaps 2,3
		pending_reqs.push_back(mk(0, 32'd3, 1, 0));            // queue full on gap fill
		pending_reqs.push_back(mk(0, 32'd3, 1, 1));            // fills upper gap
		pending_reqs.push_back(mk(0, 32'd2, 1, 1));            // fills last gap
		pending_reqs.push_back(mk(0, 32'd2, 1, 0));            // replay, ready ignored
		pending_reqs.push_back(mk(0, 32'd0, 1, 1));            // id zero replay
		pending_reqs.push_back(mk(0, 32'd68, 1, 1));           // window top edge: 64 past low
		pending_reqs.push_back(mk(0, 32'd67, 1, 1));           // last id in window
		pending_reqs.push_back(mk(0, 32'd40, 1, 1));           // fill a middle gap
		pending_reqs.push_back(mk(0, 32'hFFFF_FFFF, 1, 1));    // far outside
		pending_reqs.push_back(mk(63, 32'd64, 1, 1));          // 64 past low, outside the window
		pending_reqs.push_back(mk(63, 32'd63, 1, 1));
		pending_reqs.push_back(mk(63, 32'd1, 1, 1));
		pending_reqs.push_back(mk(63, 32'hFFFF_FFFF, 0, 0));
		pending_reqs.push_back(mk(42, 32'hAAAA_5555, 1, 1));
		pending_reqs.push_back(mk(21, 32'd1, 1, 1));

		// random: mostly near-window ids on a few clients, plus noise
		k = 0;
		while (k < 1000) begin
			c = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 3);
			base = hi_mark_guess(c);
			case ($urandom_range(0, 9))
				0: pending_reqs.push_back(mk(c, $urandom, $urandom_range(0, 1), $urandom_range(0, 1)));
				1: pending_reqs.push_back(mk(c, base + $urandom_range(1, 70), 0, $urandom_range(0, 1)));
				2, 3: pending_reqs.push_back(mk(c, base - $urandom_range(0, 66), 1,
					$urandom_range(0, 5) != 0));
				default: pending_reqs.push_back(mk(c, base + $urandom_range(1, 12), 1,
					$urandom_range(0, 5) != 0));
			endcase
			k++;
		end

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		stim_done = 1;
	end

	// End of run: drain, settle, then report.
	initial begin
		wait (stim_done);
		while ((pending_reqs.size() != 0 || in_valid || expected_verdicts.size() != 0)
				&& cycles < CYCLE_LIMIT)
			@(posedge clk);
		if (cycles >= CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end else begin
			repeat (20) @(posedge clk);
			if (mismatches == 0 && expected_verdicts.size() == 0)
				$display("status: pass");
			else
				$display("status: fail");
			$finish;
		end
	end
endmodule
